[hdl/pbcb_pkg.sv]
package pbcb_pkg;

    localparam int C_MAX_WIDTH  = 2048;
    localparam int C_MAX_HEIGHT = 4096;

    // decoupling queue between front and back
    localparam int C_Q_DEPTH = 4;

    localparam int C_CFG_IDX_W  = 3;
    localparam int C_CFG_DATA_W = 13;

    typedef enum logic [C_CFG_IDX_W-1:0] {
        CFG_GRAY_THR   = 3'd0,
        CFG_COLOR_THR  = 3'd1,
        CFG_ENEMY_SEL  = 3'd2,
        CFG_IMG_WIDTH  = 3'd3,
        CFG_IMG_HEIGHT = 3'd4
    } t_cfg_idx;

    localparam logic [7:0]  C_GRAY_THR_RST  = 8'd50;
    localparam logic [7:0]  C_COLOR_THR_RST = 8'd55;
    localparam logic [11:0] C_WIDTH_RST     = 12'd640;
    localparam logic [12:0] C_HEIGHT_RST    = 13'd480;

    // gray = (W0*c0 + W1*c1 + W2*c2 + RND) >> SHIFT
    localparam int C_GRAY_W0    = 4899;
    localparam int C_GRAY_W1    = 9617;
    localparam int C_GRAY_W2    = 1868;
    localparam int C_GRAY_RND   = 8192;
    localparam int C_GRAY_SHIFT = 14;
    localparam int C_GRAY_SUM_W = 22;
    localparam int C_P0_W       = 21;
    localparam int C_P1_W       = 22;
    localparam int C_P2_W       = 19;

    localparam int C_CS_W    = 10;   // weighted column sum, up to 4 * 255
    localparam int C_BLUR_W  = 12;   // full kernel sum, up to 16 * 255
    localparam int C_BLUR_RND = 8;
    localparam int C_BLUR_SHIFT = 4;

    typedef struct packed {
        logic [7:0]  gray_thr;
        logic [7:0]  color_thr;
        logic        enemy;
        logic [11:0] width;
        logic [12:0] height;
    } t_cfg;

    // per-item control worked out by the front
    typedef struct packed {
        logic edge_out;   // result for the right-edge pixel of the previous line
        logic mid_out;    // result for the pixel one column to the left
        logic last;       // final flush transaction of the frame
        logic lmir;       // left border: mirror right column
        logic tmir;       // top border: mirror current line
        logic wr;         // pixel line, write the line buffer
        logic sel;        // line parity, picks the buffer to overwrite
        logic cb;         // colour bit of this transaction
    } t_ctrl;

    typedef struct packed {
        logic [C_P0_W-1:0] p0;
        logic [C_P1_W-1:0] p1;
        logic [C_P2_W-1:0] p2;
    } t_prods;

endpackage

[hdl/pbcb_queue.sv]
module pbcb_queue #(
    parameter int DW    = 8,
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic [DW-1:0] o_data,
    output logic          o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp, n_wp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

[hdl/pbcb_front.sv]
module pbcb_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pbcb_pkg::t_cfg                      i_cfg,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_opcode,
    input  logic [7:0]                          i_chan0,
    input  logic [7:0]                          i_chan1,
    input  logic [7:0]                          i_chan2,
    input  logic                                i_full,
    output logic                                o_push,
    output pbcb_pkg::t_ctrl                     o_ctrl,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_x,
    output logic [$clog2(MAX_WIDTH+1)-1:0]      o_slot,
    output pbcb_pkg::t_prods                    o_prods
);
    import pbcb_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int YW = $clog2(MAX_HEIGHT + 2);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [XW-1:0] r_x, n_x;
    logic [YW-1:0] r_y, n_y;
    logic [WW-1:0] r_fw, n_fw, fw_cl, fw;
    logic [HW-1:0] r_fh, n_fh, fh_cl, fh;
    logic [WW-1:0] r_slot, n_slot, slot;
    logic [31:0]   w_req, h_req;
    logic          accept, start, flushing, drop, x_last;
    logic [7:0]    diff_a, diff_b, diff;

    assign w_req = 32'(i_cfg.width);
    assign h_req = 32'(i_cfg.height);
    assign fw_cl = (w_req < 32'd2) ? WW'(2) :
                   (w_req > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(w_req);
    assign fh_cl = (h_req < 32'd2) ? HW'(2) :
                   (h_req > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(h_req);

    assign start    = (r_x == '0) && (r_y == '0);
    // size is latched on the first pixel of a frame
    assign fw       = start ? fw_cl : r_fw;
    assign fh       = start ? fh_cl : r_fh;
    assign slot     = start ? '0 : r_slot;
    assign flushing = 32'(r_y) >= 32'(fh);
    // flush transactions only count once the frame's pixels are in
    assign drop     = i_opcode && !flushing;
    assign x_last   = 32'(r_x) == (32'(fw) - 32'd1);

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept && !drop;

    assign diff_a = i_cfg.enemy ? i_chan0 : i_chan2;
    assign diff_b = i_cfg.enemy ? i_chan2 : i_chan0;
    assign diff   = (diff_a > diff_b) ? diff_a - diff_b : 8'd0;

    always_comb begin
        o_ctrl.edge_out = (r_x == '0) && (32'(r_y) >= 32'd2);
        o_ctrl.mid_out  = (r_x != '0) && (r_y != '0);
        o_ctrl.last     = (r_x == '0) && (32'(r_y) > 32'(fh));
        o_ctrl.lmir     = (32'(r_x) == 32'd1);
        o_ctrl.tmir     = (32'(r_y) == 32'd1);
        o_ctrl.wr       = !flushing;
        o_ctrl.sel      = r_y[0];
        o_ctrl.cb       = !flushing && (diff > i_cfg.color_thr);
    end

    assign o_x    = r_x;
    assign o_slot = slot;
    assign o_prods.p0 = C_P0_W'(32'(C_GRAY_W0) * 32'(i_chan0));
    assign o_prods.p1 = C_P1_W'(32'(C_GRAY_W1) * 32'(i_chan1));
    assign o_prods.p2 = C_P2_W'(32'(C_GRAY_W2) * 32'(i_chan2));

    always_comb begin
        n_x    = r_x;
        n_y    = r_y;
        n_fw   = r_fw;
        n_fh   = r_fh;
        n_slot = r_slot;
        if (o_push) begin
            n_fw = fw;
            n_fh = fh;
            if (o_ctrl.last) begin
                n_x    = '0;
                n_y    = '0;
                n_slot = '0;
            end else begin
                n_slot = (slot == fw) ? '0 : slot + 1'b1;
                if (x_last) begin
                    n_x = '0;
                    n_y = r_y + 1'b1;
                end else begin
                    n_x = r_x + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x    <= '0;
            r_y    <= '0;
            r_fw   <= WW'(2);
            r_fh   <= HW'(2);
            r_slot <= '0;
        end else begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_fw   <= n_fw;
            r_fh   <= n_fh;
            r_slot <= n_slot;
        end
    end

endmodule

[hdl/pbcb_back.sv]
module pbcb_back #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [7:0]                          i_gray_thr,
    input  logic                                i_empty,
    input  pbcb_pkg::t_ctrl                     i_ctrl,
    input  logic [$clog2(MAX_WIDTH)-1:0]        i_x,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      i_slot,
    input  pbcb_pkg::t_prods                    i_prods,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_bright_bit,
    output logic                                o_color_bit,
    output logic                                o_frame_end
);
    import pbcb_pkg::*;

    logic                    en;
    logic [C_GRAY_SUM_W-1:0] gray_sum;
    logic [7:0]              gray;

    // line buffers: one per line parity, row y-2 sits where row y is written
    logic [7:0] r_line_a [MAX_WIDTH];
    logic [7:0] r_line_b [MAX_WIDTH];
    logic       r_cb_ring [MAX_WIDTH + 1];

    logic        r_b2_valid, r_b3_valid, r_o_valid;
    t_ctrl       r_b2_ctrl, r_b3_ctrl;
    logic [7:0]  r_b2_gray, r_rd_a, r_rd_b;
    logic        r_b2_cb, r_b3_cb;
    logic [C_CS_W-1:0] r_w0, r_w1, r_w2;
    logic        r_bright, r_color, r_end;

    logic [7:0]        top_raw, mid, top, bot;
    logic [C_CS_W-1:0] cs_new, k_a, k_c;
    logic [C_BLUR_W-1:0] blur_sum;
    logic [7:0]        blurred;
    logic              emit;

    assign en    = !r_o_valid || i_ready;
    assign o_pop = en && !i_empty;

    assign gray_sum = C_GRAY_SUM_W'(i_prods.p0) + C_GRAY_SUM_W'(i_prods.p1)
                    + C_GRAY_SUM_W'(i_prods.p2) + C_GRAY_SUM_W'(C_GRAY_RND);
    assign gray     = gray_sum[C_GRAY_SHIFT +: 8];

    // read old entry and write the new one in the same transaction
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_a <= r_line_a[i_x];
            r_rd_b <= r_line_b[i_x];
            if (i_ctrl.wr && !i_ctrl.sel) begin
                r_line_a[i_x] <= gray;
            end
            if (i_ctrl.wr && i_ctrl.sel) begin
                r_line_b[i_x] <= gray;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b2_cb           <= r_cb_ring[i_slot];
            r_cb_ring[i_slot] <= i_ctrl.cb;
        end
    end

    // column for the window: top border mirrors the current line, flush
    // lines mirror the line two above
    always_comb begin
        top_raw = r_b2_ctrl.sel ? r_rd_b : r_rd_a;
        mid     = r_b2_ctrl.sel ? r_rd_a : r_rd_b;
        if (r_b2_ctrl.wr) begin
            top = r_b2_ctrl.tmir ? r_b2_gray : top_raw;
            bot = r_b2_gray;
        end else begin
            top = top_raw;
            bot = top_raw;
        end
        cs_new = C_CS_W'(top) + C_CS_W'({mid, 1'b0}) + C_CS_W'(bot);
    end

    // window holds column sums; after a shift, w0/w1 are the previous
    // line's last two columns for a right-edge result
    always_comb begin
        k_a = (r_b3_ctrl.mid_out && r_b3_ctrl.lmir) ? r_w2 : r_w0;
        k_c = r_b3_ctrl.edge_out ? r_w0 : r_w2;
        blur_sum = C_BLUR_W'(k_a) + C_BLUR_W'({r_w1, 1'b0}) + C_BLUR_W'(k_c);
        blurred  = 8'((blur_sum + C_BLUR_W'(C_BLUR_RND)) >> C_BLUR_SHIFT);
        emit     = r_b3_valid && (r_b3_ctrl.edge_out || r_b3_ctrl.mid_out);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b2_valid <= 1'b0;
            r_b3_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (en) begin
            r_b2_valid <= o_pop;
            r_b3_valid <= r_b2_valid;
            r_o_valid  <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b2_ctrl <= i_ctrl;
            r_b2_gray <= gray;
        end
        if (en && r_b2_valid) begin
            r_b3_ctrl <= r_b2_ctrl;
            r_b3_cb   <= r_b2_cb;
            r_w0      <= r_w1;
            r_w1      <= r_w2;
            r_w2      <= cs_new;
        end
        if (en && emit) begin
            r_bright <= blurred > i_gray_thr;
            r_color  <= r_b3_cb;
            r_end    <= r_b3_ctrl.last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_bright_bit = r_bright;
    assign o_color_bit  = r_color;
    assign o_frame_end  = r_end;

endmodule

[hdl/pixel_brightness_color_binarizer_unit.sv]
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_ready  i_opcode, i_chan0, i_chan1, i_chan2
// result    out        o_valid / i_ready  o_bright_bit, o_color_bit, o_frame_end
// config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
// One transaction per cycle while the output is not stalled; the back
// pipeline (line-buffer read, window shift, blur and output register) sets
// that figure. A result follows the transaction that completes it through
// those stages, W+1 transactions after its own pixel.
// Reset is synchronous and clears control state only; line buffers and the
// colour ring hold garbage until written.
// A stalled output freezes the back pipeline; the 4-entry queue keeps the
// input side moving until it fills.
module pixel_brightness_color_binarizer_unit #(
    parameter int MAX_WIDTH  = pbcb_pkg::C_MAX_WIDTH,
    parameter int MAX_HEIGHT = pbcb_pkg::C_MAX_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_opcode,
    input  logic [7:0]                        i_chan0,
    input  logic [7:0]                        i_chan1,
    input  logic [7:0]                        i_chan2,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_bright_bit,
    output logic                              o_color_bit,
    output logic                              o_frame_end,
    input  logic                              i_cfg_we,
    input  logic [pbcb_pkg::C_CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pbcb_pkg::C_CFG_DATA_W-1:0] i_cfg_data
);
    import pbcb_pkg::*;

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int DW = $bits(t_ctrl) + XW + WW + $bits(t_prods);

    t_cfg    r_cfg;
    t_ctrl   f_ctrl, q_ctrl;
    t_prods  f_prods, q_prods;
    logic [XW-1:0] f_x, q_x;
    logic [WW-1:0] f_slot, q_slot;
    logic [DW-1:0] q_din, q_dout;
    logic          q_push, q_pop, q_full, q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gray_thr  <= C_GRAY_THR_RST;
            r_cfg.color_thr <= C_COLOR_THR_RST;
            r_cfg.enemy     <= 1'b0;
            r_cfg.width     <= C_WIDTH_RST;
            r_cfg.height    <= C_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GRAY_THR:   r_cfg.gray_thr  <= i_cfg_data[7:0];
                CFG_COLOR_THR:  r_cfg.color_thr <= i_cfg_data[7:0];
                CFG_ENEMY_SEL:  r_cfg.enemy     <= i_cfg_data[0];
                CFG_IMG_WIDTH:  r_cfg.width     <= i_cfg_data[11:0];
                CFG_IMG_HEIGHT: r_cfg.height    <= i_cfg_data[12:0];
                default: begin
                end
            endcase
        end
    end

    pbcb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_opcode (i_opcode),
        .i_chan0  (i_chan0),
        .i_chan1  (i_chan1),
        .i_chan2  (i_chan2),
        .i_full   (q_full),
        .o_push   (q_push),
        .o_ctrl   (f_ctrl),
        .o_x      (f_x),
        .o_slot   (f_slot),
        .o_prods  (f_prods)
    );

    assign q_din = {f_ctrl, f_x, f_slot, f_prods};

    pbcb_queue #(
        .DW    (DW),
        .DEPTH (C_Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_din),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_dout),
        .o_empty (q_empty)
    );

    assign {q_ctrl, q_x, q_slot, q_prods} = q_dout;

    pbcb_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_gray_thr   (r_cfg.gray_thr),
        .i_empty      (q_empty),
        .i_ctrl       (q_ctrl),
        .i_x          (q_x),
        .i_slot       (q_slot),
        .i_prods      (q_prods),
        .o_pop        (q_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_bright_bit (o_bright_bit),
        .o_color_bit  (o_color_bit),
        .o_frame_end  (o_frame_end)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

endmodule
